/* rtl/jrd_pkg.sv */
package jrd_pkg;

   // Angle arithmetic of the vectoring unit: radians in units of 2^-20.
   localparam int CORDIC_ITERS = 20;
   localparam int ZW           = 24;
   localparam int ANGLE_W      = 16;
   localparam int PRE_SHIFT    = 12;
   localparam int ROUND_SHIFT  = 7;

   localparam logic signed [ZW-1:0]      HALF_PI_U20 = 24'sd1647099;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX   = 16'sd25736;
   localparam logic signed [ZW-1:0]      ROUND_BIAS  = 24'sd64;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DZ_W       = 16;
   localparam logic [DZ_W-1:0] DEADZONE_RESET = 16'd4915;

   typedef enum logic [0:0] {
      REG_DEADZONE = 1'b0
   } reg_index_type;

   // Angle codes that bypass the vectoring result.
   typedef enum logic [1:0] {
      ANG_NORMAL = 2'd0,
      ANG_ZERO   = 2'd1,
      ANG_NEG_PI = 2'd2
   } ang_special_type;

   function automatic logic signed [ZW-1:0] atan_step(input int i);
      logic signed [ZW-1:0] v;
      begin
         unique case (i)
            0:  v = 24'sd823550;
            1:  v = 24'sd486170;
            2:  v = 24'sd256879;
            3:  v = 24'sd130396;
            4:  v = 24'sd65451;
            5:  v = 24'sd32757;
            6:  v = 24'sd16383;
            7:  v = 24'sd8192;
            8:  v = 24'sd4096;
            9:  v = 24'sd2048;
            10: v = 24'sd1024;
            11: v = 24'sd512;
            12: v = 24'sd256;
            13: v = 24'sd128;
            14: v = 24'sd64;
            15: v = 24'sd32;
            16: v = 24'sd16;
            17: v = 24'sd8;
            18: v = 24'sd4;
            19: v = 24'sd2;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/jrd_csr.sv */
module jrd_csr import jrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [DZ_W-1:0]       deadzone
);

   logic [DZ_W-1:0] dz_ff;
   logic [DZ_W-1:0] dz_in;
   logic            hit;

   // Registers are word spaced, so the index sits above the byte offset.
   assign hit = (reg_index_type'(csr_paddr[2]) == REG_DEADZONE);

   always_comb begin
      dz_in = dz_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         dz_in = csr_pwdata[DZ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DEADZONE_RESET;
      end else begin
         dz_ff <= dz_in;
      end
   end

   assign csr_prdata = hit ? {{(CSR_DATA_W-DZ_W){1'b0}}, dz_ff} : '0;
   assign csr_pready = 1'b1;
   assign deadzone   = dz_ff;

endmodule

/* rtl/jrd_mag.sv */
module jrd_mag import jrd_pkg::*; #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic [W+2:0]        load,
   input  logic signed [W-1:0] x_in,
   input  logic signed [W-1:0] y_in,
   output logic signed [W-1:0] x_o,
   output logic signed [W-1:0] y_o,
   output logic                over_o,
   output logic [W-1:0]        mag_o
);

   localparam int N = W + 3;
   localparam logic [2*W-1:0] ONE_SQ = {{(2*W-1){1'b0}}, 1'b1} << (2*W-2);

   logic signed [W-1:0]   x_ff   [0:N-1];
   logic signed [W-1:0]   y_ff   [0:N-1];
   logic                  ov_ff  [1:N-1];
   logic signed [2*W-1:0] xx_ff;
   logic signed [2*W-1:0] yy_ff;
   logic [2*W-1:0]        r_ff   [1:W+1];
   logic [2*W-1:0]        rem_ff [1:W+1];
   logic [W-1:0]          mag_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         xx_ff   <= x_in * x_in;
         yy_ff   <= y_in * y_in;
      end
      if (load[1]) begin
         rem_ff[1] <= xx_ff + yy_ff;
         r_ff[1]   <= '0;
         ov_ff[1]  <= ((xx_ff + yy_ff) > ONE_SQ);
      end
   end

   genvar k;
   generate
      for (k = 1; k < N; k++) begin : g_carry
         always_ff @(posedge clock) begin
            if (load[k]) begin
               x_ff[k] <= x_ff[k-1];
               y_ff[k] <= y_ff[k-1];
            end
         end
      end
      for (k = 2; k < N; k++) begin : g_ov
         always_ff @(posedge clock) begin
            if (load[k]) begin
               ov_ff[k] <= ov_ff[k-1];
            end
         end
      end
      // One result bit of the square root per stage.
      for (k = 0; k < W; k++) begin : g_sqrt
         localparam logic [2*W-1:0] BIT = {{(2*W-1){1'b0}}, 1'b1} << (2*(W-1-k));
         logic [2*W-1:0] t;
         assign t = r_ff[k+1] + BIT;
         always_ff @(posedge clock) begin
            if (load[k+2]) begin
               if (rem_ff[k+1] >= t) begin
                  rem_ff[k+2] <= rem_ff[k+1] - t;
                  r_ff[k+2]   <= (r_ff[k+1] >> 1) + BIT;
               end else begin
                  rem_ff[k+2] <= rem_ff[k+1];
                  r_ff[k+2]   <= r_ff[k+1] >> 1;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (load[N-1]) begin
         mag_ff <= (rem_ff[W+1] > r_ff[W+1]) ? (r_ff[W+1][W-1:0] + 1'b1)
                                              : r_ff[W+1][W-1:0];
      end
   end

   assign x_o    = x_ff[N-1];
   assign y_o    = y_ff[N-1];
   assign over_o = ov_ff[N-1];
   assign mag_o  = mag_ff;

endmodule

/* rtl/jrd_div.sv */
module jrd_div import jrd_pkg::*; #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic [W+1:0]        load,
   input  logic signed [W-1:0] x_in,
   input  logic signed [W-1:0] y_in,
   input  logic                over_in,
   input  logic [W-1:0]        mag_in,
   output logic signed [W-1:0] x_o,
   output logic signed [W-1:0] y_o,
   output logic                over_o,
   output logic [W-1:0]        mag_o,
   output logic [W:0]          qx_o,
   output logic [W:0]          qy_o
);

   localparam int N  = W + 2;
   localparam int RW = 2*W + 1;

   logic signed [W-1:0] x_ff   [0:N-1];
   logic signed [W-1:0] y_ff   [0:N-1];
   logic                ov_ff  [0:N-1];
   logic [W-1:0]        mag_ff [0:N-1];
   logic [RW-1:0]       rx_ff  [0:N-1];
   logic [RW-1:0]       ry_ff  [0:N-1];
   logic [W:0]          qx_ff  [0:N-1];
   logic [W:0]          qy_ff  [0:N-1];

   logic [W:0]    sx, sy;
   logic [W-1:0]  ax, ay;
   logic [RW-1:0] half;

   assign sx   = -{x_in[W-1], x_in};
   assign sy   = -{y_in[W-1], y_in};
   assign ax   = x_in[W-1] ? sx[W-1:0] : x_in;
   assign ay   = y_in[W-1] ? sy[W-1:0] : y_in;
   assign half = {{(W+2){1'b0}}, mag_in[W-1:1]};

   always_ff @(posedge clock) begin
      if (load[0]) begin
         x_ff[0]   <= x_in;
         y_ff[0]   <= y_in;
         ov_ff[0]  <= over_in;
         mag_ff[0] <= mag_in;
         rx_ff[0]  <= ({{(W+1){1'b0}}, ax} << (W-1)) + half;
         ry_ff[0]  <= ({{(W+1){1'b0}}, ay} << (W-1)) + half;
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
      end
   end

   // Restoring division, quotient bit W first, one bit per stage.
   genvar s;
   generate
      for (s = 1; s < N; s++) begin : g_step
         localparam int B = W - (s - 1);
         logic [RW-1:0] d;
         assign d = {{(W+1){1'b0}}, mag_ff[s-1]} << B;
         always_ff @(posedge clock) begin
            if (load[s]) begin
               x_ff[s]   <= x_ff[s-1];
               y_ff[s]   <= y_ff[s-1];
               ov_ff[s]  <= ov_ff[s-1];
               mag_ff[s] <= mag_ff[s-1];
               if (rx_ff[s-1] >= d) begin
                  rx_ff[s] <= rx_ff[s-1] - d;
                  qx_ff[s] <= qx_ff[s-1] | ({{W{1'b0}}, 1'b1} << B);
               end else begin
                  rx_ff[s] <= rx_ff[s-1];
                  qx_ff[s] <= qx_ff[s-1];
               end
               if (ry_ff[s-1] >= d) begin
                  ry_ff[s] <= ry_ff[s-1] - d;
                  qy_ff[s] <= qy_ff[s-1] | ({{W{1'b0}}, 1'b1} << B);
               end else begin
                  ry_ff[s] <= ry_ff[s-1];
                  qy_ff[s] <= qy_ff[s-1];
               end
            end
         end
      end
   endgenerate

   assign x_o    = x_ff[N-1];
   assign y_o    = y_ff[N-1];
   assign over_o = ov_ff[N-1];
   assign mag_o  = mag_ff[N-1];
   assign qx_o   = qx_ff[N-1];
   assign qy_o   = qy_ff[N-1];

endmodule

/* rtl/jrd_cordic.sv */
module jrd_cordic import jrd_pkg::*; #(
   parameter int W     = 16,
   parameter int DEPTH = 37
) (
   input  logic                 clock,
   input  logic [DEPTH-1:0]     load,
   input  logic signed [W-1:0]  x_in,
   input  logic signed [W-1:0]  y_in,
   output logic signed [ZW-1:0] z_o,
   output ang_special_type      spec_o
);

   localparam int CW = W + 16;

   logic signed [CW-1:0] cx_ff [0:DEPTH-1];
   logic signed [CW-1:0] cy_ff [0:DEPTH-1];
   logic signed [ZW-1:0] z_ff  [0:DEPTH-1];
   ang_special_type      sp_ff [0:DEPTH-1];

   logic [W:0]           a;
   logic signed [CW-1:0] ax, bx, px, py;
   logic signed [ZW-1:0] pz;
   ang_special_type      sp;

   // The vector is (b, a) = (y, -x); a quadrant turn brings it to the right half.
   always_comb begin
      a  = -{x_in[W-1], x_in};
      ax = $signed({{(CW-W-1){a[W]}}, a}) <<< PRE_SHIFT;
      bx = $signed({{(CW-W){y_in[W-1]}}, y_in}) <<< PRE_SHIFT;
      px = bx;
      py = ax;
      pz = '0;
      if (bx < 0) begin
         if (ax > 0) begin
            px = ax;
            py = -bx;
            pz = HALF_PI_U20;
         end else begin
            px = -ax;
            py = bx;
            pz = -HALF_PI_U20;
         end
      end
      if (x_in == '0 && y_in == '0) begin
         sp = ANG_ZERO;
      end else if (x_in == '0 && y_in[W-1]) begin
         sp = ANG_NEG_PI;
      end else begin
         sp = ANG_NORMAL;
      end
   end

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_stage
         logic signed [CW-1:0] ix, iy;
         logic signed [ZW-1:0] iz;
         if (k == 0) begin : g_src
            assign ix = px;
            assign iy = py;
            assign iz = pz;
            always_ff @(posedge clock) begin
               if (load[k]) begin
                  sp_ff[k] <= sp;
               end
            end
         end else begin : g_src
            assign ix = cx_ff[k-1];
            assign iy = cy_ff[k-1];
            assign iz = z_ff[k-1];
            always_ff @(posedge clock) begin
               if (load[k]) begin
                  sp_ff[k] <= sp_ff[k-1];
               end
            end
         end
         if (k < CORDIC_ITERS) begin : g_iter
            always_ff @(posedge clock) begin
               if (load[k]) begin
                  if (!iy[CW-1]) begin
                     cx_ff[k] <= ix + (iy >>> k);
                     cy_ff[k] <= iy - (ix >>> k);
                     z_ff[k]  <= iz + atan_step(k);
                  end else begin
                     cx_ff[k] <= ix - (iy >>> k);
                     cy_ff[k] <= iy + (ix >>> k);
                     z_ff[k]  <= iz - atan_step(k);
                  end
               end
            end
         end else begin : g_hold
            always_ff @(posedge clock) begin
               if (load[k]) begin
                  cx_ff[k] <= ix;
                  cy_ff[k] <= iy;
                  z_ff[k]  <= iz;
               end
            end
         end
      end
   endgenerate

   assign z_o    = z_ff[DEPTH-1];
   assign spec_o = sp_ff[DEPTH-1];

endmodule

/* rtl/joystick_radial_deadzone.sv */
// Channel  Direction  Transfer content (tdata, lowest bits first)
// req      in         x_sample, y_sample
// rsp      out        x_out, y_out, magnitude, angle
// csr      in/out     APB write/read of the deadzone threshold
//
// The pipeline holds the square root, one result bit per stage, followed by the
// normalizing divider, one quotient bit per stage. The angle unit runs alongside.
// One sample may be transferred every cycle while the result is taken or a stage
// is empty. A stalled result holds the full stages directly behind it; stages behind
// an empty one keep accepting, and a full pipeline stalls without loss.
// Reset, synchronous and active high, empties the pipeline and restores the threshold.
module joystick_radial_deadzone import jrd_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // x_sample, y_sample
   input  logic [((2*SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // x_out, y_out, magnitude, angle
   output logic [((3*SAMPLE_WIDTH + ANGLE_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int W     = SAMPLE_WIDTH;
   localparam int RSP_W = ((3*W + ANGLE_W + 7) / 8) * 8;
   localparam int D     = 2*W + 6;
   localparam int MAG_N = W + 3;
   localparam int DIV_N = W + 2;
   localparam logic [W:0] ONE = {1'b0, 1'b1, {(W-1){1'b0}}};

   // Stage k loads when it is empty or its content moves on in the same cycle.
   logic [D-1:0] v_ff;
   logic [D-1:0] v_in;
   logic [D-1:0] load;

   always_comb begin
      load[D-1] = !v_ff[D-1] || rsp_tready;
      for (int k = D - 2; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
      for (int k = 0; k < D; k++) begin
         if (!load[k]) begin
            v_in[k] = v_ff[k];
         end else if (k == 0) begin
            v_in[k] = req_tvalid;
         end else begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = load[0];
   assign rsp_tvalid = v_ff[D-1];

   logic [DZ_W-1:0] deadzone;

   jrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .deadzone    (deadzone)
   );

   logic signed [W-1:0] x_s, y_s;
   assign x_s = req_tdata[W-1:0];
   assign y_s = req_tdata[2*W-1:W];

   logic signed [W-1:0] m_x, m_y;
   logic                m_ov;
   logic [W-1:0]        m_mag;

   jrd_mag #(.W(W)) u_mag (
      .clock  (clock),
      .load   (load[MAG_N-1:0]),
      .x_in   (x_s),
      .y_in   (y_s),
      .x_o    (m_x),
      .y_o    (m_y),
      .over_o (m_ov),
      .mag_o  (m_mag)
   );

   logic signed [W-1:0] d_x, d_y;
   logic                d_ov;
   logic [W-1:0]        d_mag;
   logic [W:0]          d_qx, d_qy;

   jrd_div #(.W(W)) u_div (
      .clock   (clock),
      .load    (load[MAG_N+DIV_N-1:MAG_N]),
      .x_in    (m_x),
      .y_in    (m_y),
      .over_in (m_ov),
      .mag_in  (m_mag),
      .x_o     (d_x),
      .y_o     (d_y),
      .over_o  (d_ov),
      .mag_o   (d_mag),
      .qx_o    (d_qx),
      .qy_o    (d_qy)
   );

   logic signed [ZW-1:0] c_z;
   ang_special_type      c_sp;

   jrd_cordic #(.W(W), .DEPTH(D-1)) u_cordic (
      .clock  (clock),
      .load   (load[D-2:0]),
      .x_in   (x_s),
      .y_in   (y_s),
      .z_o    (c_z),
      .spec_o (c_sp)
   );

   // The threshold is kept in Q1.15 and brought to the sample format by a shift.
   logic [W-1:0] dz_s;
   generate
      if (W >= DZ_W) begin : g_dz_up
         assign dz_s = W'(deadzone) << (W - DZ_W);
      end else begin : g_dz_dn
         assign dz_s = W'(deadzone >> (DZ_W - W));
      end
   endgenerate

   // Normalized components: signed quotient saturated to the sample range.
   function automatic logic [W-1:0] sat_comp(input logic neg, input logic [W:0] q);
      logic [W:0] r;
      begin
         if (!neg) begin
            r = (q > ONE - 1'b1) ? ONE - 1'b1 : q;
         end else begin
            r = (q > ONE) ? -ONE : -q;
         end
         return r[W-1:0];
      end
   endfunction

   logic signed [ZW-1:0]      zr;
   logic signed [ZW-ROUND_SHIFT-1:0] zq;
   logic signed [ANGLE_W-1:0] ang;
   logic                      dead;
   logic [W-1:0]              xo, yo, mo;

   always_comb begin
      zr   = c_z + ROUND_BIAS;
      zq   = zr[ZW-1:ROUND_SHIFT];
      if (zq > ZW'(ANGLE_MAX)) begin
         ang = ANGLE_MAX;
      end else if (zq < -ZW'(ANGLE_MAX)) begin
         ang = -ANGLE_MAX;
      end else begin
         ang = zq[ANGLE_W-1:0];
      end
      unique case (c_sp)
         ANG_ZERO:   ang = '0;
         ANG_NEG_PI: ang = -ANGLE_MAX;
         default:    ;
      endcase

      dead = (d_mag <= dz_s);
      if (dead) begin
         xo = '0;
         yo = '0;
         mo = '0;
      end else if (d_ov) begin
         xo = sat_comp(d_x[W-1], d_qx);
         yo = sat_comp(d_y[W-1], d_qy);
         mo = ONE[W-1:0];
      end else begin
         xo = d_x;
         yo = d_y;
         mo = d_mag;
      end
   end

   logic [RSP_W-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (load[D-1]) begin
         out_ff <= RSP_W'({ang, mo, yo, xo});
      end
   end

   assign rsp_tdata = out_ff;

endmodule

/* rtl/jrd_checker.sv */
module jrd_checker import jrd_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [((3*SAMPLE_WIDTH + ANGLE_W + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int W     = SAMPLE_WIDTH;
   localparam logic [W-1:0] ONE = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]              mag;
   logic signed [ANGLE_W-1:0] ang;
   assign mag = rsp_tdata[3*W-1:2*W];
   assign ang = rsp_tdata[3*W+ANGLE_W-1:3*W];

   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> mag <= ONE)
      else $error("magnitude above one");

   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ang <= ANGLE_MAX) && (ang >= -ANGLE_MAX))
      else $error("angle out of range");

endmodule

bind joystick_radial_deadzone jrd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_jrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
